[hdl/i2cm_pkg.sv]
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master byte engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

   localparam int TICK_W = 10;

   // Command classes handed from the front end to the sequencer
   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_NONE  = 2'd0;
   localparam cmd_type CMD_WRITE = 2'd1;
   localparam cmd_type CMD_READ  = 2'd2;

   // Timing register indexes on the configuration channel
   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_LOW_TICKS  = 2'd0;
   localparam csr_index_type CSR_HIGH_TICKS = 2'd1;
   localparam csr_index_type CSR_START_HOLD = 2'd2;

   // One queued tick: classified command, its byte and start/stop flags, plus the sampled bus lines
   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data_byte;
      logic       with_start;
      logic       with_stop;
      logic       scl_in;
      logic       sda_in;
   } q_entry_type;

endpackage : i2cm_pkg

`default_nettype wire

[hdl/i2cm_if.sv]
// ----------------------------------------------------------------------------
// i2cm_if
// Valid/ready channels of the I2C master byte engine: tick requests,
// per-tick results and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] data_byte;
   logic       with_start;
   logic       with_stop;
   logic       scl_in;
   logic       sda_in;

   modport source (output valid, operation, data_byte, with_start, with_stop,
                   scl_in, sda_in, input ready);
   modport sink   (input valid, operation, data_byte, with_start, with_stop,
                   scl_in, sda_in, output ready);
endinterface : i2cm_req_if

interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_release;
   logic       sda_release;
   logic       busy_res;
   logic       done_res;
   logic       ack_received;
   logic [7:0] read_data;

   modport source  (output valid, scl_release, sda_release, busy_res, done_res,
                    ack_received, read_data, input ready);
   modport sink    (input valid, scl_release, sda_release, busy_res, done_res,
                    ack_received, read_data, output ready);
   modport monitor (input valid, ready, scl_release, sda_release, busy_res,
                    done_res, ack_received, read_data);
endinterface : i2cm_rsp_if

interface i2cm_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [9:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface : i2cm_csr_if

`default_nettype wire

[hdl/i2cm_front.sv]
// ----------------------------------------------------------------------------
// i2cm_front
// Request front end: classify the operation code and hold ticks in a
// two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   i2cm_req_if.sink                   req_ch,
   output      logic                  q_valid,
   output      i2cm_pkg::q_entry_type q_entry,
   input  wire logic                  q_pop
);
   import i2cm_pkg::*;

   q_entry_type entry_ff [2];
   q_entry_type push_entry;
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;

   always_comb begin
      push_entry.cmd        = CMD_NONE;
      if (req_ch.operation == CMD_WRITE) begin
         push_entry.cmd = CMD_WRITE;
      end else if (req_ch.operation == CMD_READ) begin
         push_entry.cmd = CMD_READ;
      end
      push_entry.data_byte  = req_ch.data_byte;
      push_entry.with_start = req_ch.with_start;
      push_entry.with_stop  = req_ch.with_stop;
      push_entry.scl_in     = req_ch.scl_in;
      push_entry.sda_in     = req_ch.sda_in;
   end

   assign req_ch.ready = (count_ff != 2'd2);
   assign push         = req_ch.valid && req_ch.ready;
   assign q_valid      = (count_ff != 2'd0);
   assign q_entry      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule : i2cm_front

`default_nettype wire

[hdl/i2cm_back.sv]
// ----------------------------------------------------------------------------
// i2cm_back
// Bus sequencer: step the start / bit / acknowledge / stop phases once per
// queued tick, hold the timing registers and register each result.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_valid,
   input  wire i2cm_pkg::q_entry_type q_entry,
   output      logic                  q_pop,
   i2cm_csr_if.sink                   csr_ch,
   i2cm_rsp_if.source                 rsp_ch
);
   import i2cm_pkg::*;

   localparam logic [3:0] PH_IDLE        = 4'd0;
   localparam logic [3:0] PH_START_RISE  = 4'd1;
   localparam logic [3:0] PH_START_SETUP = 4'd2;
   localparam logic [3:0] PH_START_HOLD  = 4'd3;
   localparam logic [3:0] PH_BIT_LOW     = 4'd4;
   localparam logic [3:0] PH_BIT_RISE    = 4'd5;
   localparam logic [3:0] PH_BIT_HIGH    = 4'd6;
   localparam logic [3:0] PH_STOP_LOW    = 4'd7;
   localparam logic [3:0] PH_STOP_RISE   = 4'd8;
   localparam logic [3:0] PH_STOP_HOLD   = 4'd9;

   localparam logic [3:0] ACK_SLOT = 4'd8;

   // Data bit for the low half of a slot; released for read and acknowledge
   function automatic logic low_sda(input logic [7:0] shift, input logic [3:0] bits,
                                    input logic rd);
      logic [2:0] idx;
      idx = 3'd7 - bits[2:0];
      if (bits < ACK_SLOT && !rd) begin
         return shift[idx];
      end
      return 1'b1;
   endfunction

   logic [TICK_W-1:0] low_ticks_ff, high_ticks_ff, hold_ticks_ff;

   logic [3:0]        phase_ff, phase_in;
   logic [7:0]        shift_ff, shift_in;
   logic [3:0]        bit_ff, bit_in;
   logic [TICK_W-1:0] tick_ff, tick_in, tick_next;
   logic              is_read_ff, is_read_in;
   logic              stop_ff, stop_in;
   logic              ack_ff, ack_in;
   logic              scl_ff, scl_in;
   logic              sda_ff, sda_in;
   logic [7:0]        hold_ff, hold_in;
   logic              done;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_scl_ff, rsp_sda_ff, rsp_busy_ff, rsp_done_ff, rsp_ack_ff;
   logic [7:0]        rsp_data_ff;

   assign csr_ch.ready = 1'b1;
   assign q_pop        = q_valid && (!rsp_valid_ff || rsp_ch.ready);
   assign tick_next    = tick_ff + 1'b1;

   always_comb begin
      phase_in   = phase_ff;
      shift_in   = shift_ff;
      bit_in     = bit_ff;
      tick_in    = tick_ff;
      is_read_in = is_read_ff;
      stop_in    = stop_ff;
      ack_in     = ack_ff;
      scl_in     = scl_ff;
      sda_in     = sda_ff;
      hold_in    = hold_ff;
      done       = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (q_entry.cmd == CMD_WRITE || q_entry.cmd == CMD_READ) begin
               is_read_in = (q_entry.cmd == CMD_READ);
               stop_in    = q_entry.with_stop;
               shift_in   = is_read_in ? 8'd0 : q_entry.data_byte;
               bit_in     = 4'd0;
               tick_in    = '0;
               if (q_entry.with_start) begin
                  phase_in = PH_START_RISE;
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
               end else begin
                  phase_in = PH_BIT_LOW;
                  scl_in   = 1'b0;
                  sda_in   = low_sda(shift_in, bit_in, is_read_in);
               end
            end
         end
         PH_START_RISE: begin
            if (q_entry.scl_in) begin
               phase_in = PH_START_SETUP;
               tick_in  = '0;
            end
         end
         PH_START_SETUP: begin
            tick_in = tick_next;
            if (tick_next >= high_ticks_ff) begin
               phase_in = PH_START_HOLD;
               tick_in  = '0;
               sda_in   = 1'b0;
            end
         end
         PH_START_HOLD: begin
            tick_in = tick_next;
            if (tick_next >= hold_ticks_ff) begin
               phase_in = PH_BIT_LOW;
               tick_in  = '0;
               scl_in   = 1'b0;
               sda_in   = low_sda(shift_ff, bit_ff, is_read_ff);
            end
         end
         PH_BIT_LOW: begin
            tick_in = tick_next;
            if (tick_next >= low_ticks_ff) begin
               phase_in = PH_BIT_RISE;
               scl_in   = 1'b1;
            end
         end
         PH_BIT_RISE: begin
            if (q_entry.scl_in) begin
               if (bit_ff < ACK_SLOT) begin
                  if (is_read_ff) begin
                     shift_in = {shift_ff[6:0], q_entry.sda_in};
                  end
               end else if (!is_read_ff) begin
                  ack_in = ~q_entry.sda_in;
               end
               phase_in = PH_BIT_HIGH;
               tick_in  = '0;
            end
         end
         PH_BIT_HIGH: begin
            tick_in = tick_next;
            if (tick_next >= high_ticks_ff) begin
               if (bit_ff < ACK_SLOT) begin
                  bit_in   = bit_ff + 4'd1;
                  phase_in = PH_BIT_LOW;
                  tick_in  = '0;
                  scl_in   = 1'b0;
                  sda_in   = low_sda(shift_ff, bit_in, is_read_ff);
               end else if (stop_ff) begin
                  phase_in = PH_STOP_LOW;
                  tick_in  = '0;
                  scl_in   = 1'b0;
                  sda_in   = 1'b0;
               end else begin
                  phase_in = PH_IDLE;
                  scl_in   = 1'b0;
                  sda_in   = 1'b1;
                  if (is_read_ff) begin
                     hold_in = shift_ff;
                  end
                  done = 1'b1;
               end
            end
         end
         PH_STOP_LOW: begin
            tick_in = tick_next;
            if (tick_next >= low_ticks_ff) begin
               phase_in = PH_STOP_RISE;
               scl_in   = 1'b1;
            end
         end
         PH_STOP_RISE: begin
            if (q_entry.scl_in) begin
               phase_in = PH_STOP_HOLD;
               tick_in  = '0;
            end
         end
         PH_STOP_HOLD: begin
            tick_in = tick_next;
            if (tick_next >= hold_ticks_ff) begin
               phase_in = PH_IDLE;
               sda_in   = 1'b1;
               if (is_read_ff) begin
                  hold_in = shift_ff;
               end
               done = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (q_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ticks_ff  <= TICK_W'(12);
         high_ticks_ff <= TICK_W'(18);
         hold_ticks_ff <= TICK_W'(24);
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_LOW_TICKS:  low_ticks_ff  <= csr_ch.data;
            CSR_HIGH_TICKS: high_ticks_ff <= csr_ch.data;
            CSR_START_HOLD: hold_ticks_ff <= csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         shift_ff     <= 8'd0;
         bit_ff       <= 4'd0;
         tick_ff      <= '0;
         is_read_ff   <= 1'b0;
         stop_ff      <= 1'b0;
         ack_ff       <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         hold_ff      <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            phase_ff   <= phase_in;
            shift_ff   <= shift_in;
            bit_ff     <= bit_in;
            tick_ff    <= tick_in;
            is_read_ff <= is_read_in;
            stop_ff    <= stop_in;
            ack_ff     <= ack_in;
            scl_ff     <= scl_in;
            sda_ff     <= sda_in;
            hold_ff    <= hold_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_scl_ff  <= scl_in;
         rsp_sda_ff  <= sda_in;
         rsp_busy_ff <= (phase_in != PH_IDLE);
         rsp_done_ff <= done;
         rsp_ack_ff  <= ack_in;
         rsp_data_ff <= hold_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.scl_release  = rsp_scl_ff;
   assign rsp_ch.sda_release  = rsp_sda_ff;
   assign rsp_ch.busy_res     = rsp_busy_ff;
   assign rsp_ch.done_res     = rsp_done_ff;
   assign rsp_ch.ack_received = rsp_ack_ff;
   assign rsp_ch.read_data    = rsp_data_ff;

endmodule : i2cm_back

`default_nettype wire

[hdl/i2c_master_byte_engine_unit.sv]
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_unit
// Open-drain I2C master that moves one byte per command, one bus tick per
// request.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch  - one request per bus tick: sampled SCL/SDA plus an optional
//             command (write byte, or read byte answered with NACK), each with
//             an optional start before and stop after the byte.
//   rsp_ch  - one result per request: SCL/SDA release after that tick,
//             busy, a done pulse, the last acknowledge and the last read byte.
//   csr_ch  - timing writes (low, high and start/stop hold tick counts);
//             always ready, write only while no request is outstanding.
// Path: each request is registered in the request queue, and its result in
//   the result register, before the result turns valid on rsp_ch.
// Throughput: one request per clock while rsp_ch takes each result; the sequencer steps once per request.
// Reset: synchronous; lines released, sequencer idle, timing registers back
//   to 12/18/24, queue and result register empty.
// Stall: while rsp_ch is held off the result register holds its value and
//   the sequencer pauses; the two-entry queue takes up to two more requests
//   before req_ch.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   i2cm_req_if.sink   req_ch,
   i2cm_rsp_if.source rsp_ch,
   i2cm_csr_if.sink   csr_ch
);
   import i2cm_pkg::*;

   // Queue between classifier and sequencer
   logic        q_valid;
   logic        q_pop;
   q_entry_type q_entry;

   // Classify and buffer incoming ticks
   i2cm_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .q_pop   (q_pop)
   );

   // Step the bus phases and drive the result register
   i2cm_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .q_pop   (q_pop),
      .csr_ch  (csr_ch),
      .rsp_ch  (rsp_ch)
   );

endmodule : i2c_master_byte_engine_unit

`default_nettype wire

[hdl/i2cm_checker.sv]
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks on the result channel of the I2C master byte engine.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_scl,
   input wire logic       rsp_sda,
   input wire logic       rsp_busy,
   input wire logic       rsp_done,
   input wire logic [7:0] rsp_data
);

   // A finished command leaves the engine idle in the same result
   a_done_not_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done |-> !rsp_busy)
      else $error("done pulse while busy");

   // Idle always leaves SDA released
   a_idle_sda : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy |-> rsp_sda)
      else $error("SDA driven low while idle");

   // No result right after reset
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // Stalled result holds
   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)
         && $stable(rsp_done) && $stable(rsp_scl) && $stable(rsp_sda)
         && $stable(rsp_busy))
      else $error("stalled result changed");

endmodule : i2cm_checker

bind i2c_master_byte_engine_unit i2cm_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_scl   (rsp_ch.scl_release),
   .rsp_sda   (rsp_ch.sda_release),
   .rsp_busy  (rsp_ch.busy_res),
   .rsp_done  (rsp_ch.done_res),
   .rsp_data  (rsp_ch.read_data)
);

`default_nettype wire
